### rtl/sbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and fixed constants for the separable box mean filter.
// ----------------------------------------------------------------------------
package sbf_pkg;

  // pixel and field widths
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int CH_MAX     = 255;
  localparam int ROW_W      = 11;
  localparam int OUT_COL_W  = 10;
  localparam int WID_CFG_W  = 11;
  localparam int HGT_CFG_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  // frame limits and reset geometry
  localparam int MAX_HEIGHT   = 2048;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // pipeline stage enables
  typedef struct packed {
    logic acc;
    logic adv1;
    logic adv2;
    logic adv3;
  } pipe_ctl_t;

  // per-pixel position info that travels with the pipeline
  typedef struct packed {
    logic                 live;       // row holds a full vertical window
    logic                 first_row;
    logic                 first_col;
    logic                 drop_old;   // horizontal window is full, drop oldest
    logic                 emit;       // interior pixel, produces a result
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } side_t;

  // width of a biased channel sum over 2*radius+1 taps
  function automatic int sum_w(input int radius);
    return $clog2(CH_MAX * (2 * radius + 1) + radius + 1);
  endfunction

endpackage

### rtl/sbf_rmean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_rmean
// Rounded mean of one channel: biased sum divided by 2*RADIUS+1 through a
// reciprocal multiply, exact over the whole sum range.
// ----------------------------------------------------------------------------
module sbf_rmean #(
  parameter int RADIUS = 10,
  localparam int TAPS = 2 * RADIUS + 1,
  localparam int SW   = sbf_pkg::sum_w(RADIUS)
) (
  input  logic [SW-1:0]            sum_i,
  output logic [sbf_pkg::CH_W-1:0] mean_o
);

  // reciprocal with round-up, shift chosen so the floor is exact for sum_i
  localparam int SHIFT = SW + $clog2(TAPS);
  localparam int RECIP = (2 ** SHIFT + TAPS - 1) / TAPS;
  localparam int PW    = SHIFT + sbf_pkg::CH_W;

  logic [PW-1:0] prod;

  assign prod   = PW'(sum_i) * PW'(RECIP);
  assign mean_o = prod[SHIFT +: sbf_pkg::CH_W];

endmodule

### rtl/sbf_vpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_vpass
// Vertical pass: line store, per-column running sums and the vertical
// rounded mean, two pipeline stages after the input register.
// ----------------------------------------------------------------------------
module sbf_vpass #(
  parameter int RADIUS    = 10,
  parameter int MAX_WIDTH = 1024,
  localparam int LINES = 2 * RADIUS,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int AW    = $clog2(LINES * MAX_WIDTH),
  localparam int SW    = sbf_pkg::sum_w(RADIUS)
) (
  input  logic                      clk,
  input  sbf_pkg::pipe_ctl_t        ctl,
  input  logic [sbf_pkg::PIX_W-1:0] in_pix,
  input  logic [AW-1:0]             line_addr,
  input  logic [CW-1:0]             in_col,
  input  sbf_pkg::side_t            s1_side,
  input  logic [CW-1:0]             s1_col,
  output logic [sbf_pkg::PIX_W-1:0] s3_mid
);

  localparam int CH_W = sbf_pkg::CH_W;

  // memories
  logic [sbf_pkg::PIX_W-1:0] line_mem [LINES * MAX_WIDTH];
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] csum_mem [MAX_WIDTH];

  // stage registers
  logic [sbf_pkg::PIX_W-1:0]          pix1_r;
  logic [sbf_pkg::PIX_W-1:0]          evict1_r;
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] csum1_r;
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] vx2_r;
  logic [sbf_pkg::PIX_W-1:0]          mid3_r;

  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] csum_nxt;
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] vx_nxt;
  logic [sbf_pkg::PIX_W-1:0]          mid_nxt;

  // line store: read the evicted pixel and write the new one at one address
  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      line_mem[line_addr] <= in_pix;
      evict1_r            <= line_mem[line_addr];
      pix1_r              <= in_pix;
    end
  end

  // column sum store: read on accept, write back when stage 1 retires
  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      csum_mem[s1_col] <= csum_nxt;
    end
    if (ctl.acc) begin
      csum1_r <= csum_mem[in_col];
    end
  end

  // stage 1: window sum and next column sum per channel
  for (genvar ch = 0; ch < sbf_pkg::NUM_CH; ch++) begin : g_vsum
    logic [SW-1:0] base;
    logic [SW-1:0] vsum;
    logic [SW-1:0] evict;

    assign base  = s1_side.first_row ? '0 : csum1_r[ch];
    assign vsum  = base + SW'(pix1_r[CH_W*ch +: CH_W]);
    assign evict = s1_side.live ? SW'(evict1_r[CH_W*ch +: CH_W]) : '0;
    assign csum_nxt[ch] = vsum - evict;
    assign vx_nxt[ch]   = vsum + SW'(RADIUS);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      vx2_r <= vx_nxt;
    end
  end

  // stage 2: vertical rounded mean
  for (genvar ch = 0; ch < sbf_pkg::NUM_CH; ch++) begin : g_vmean
    sbf_rmean #(
      .RADIUS (RADIUS)
    ) u_rmean (
      .sum_i  (vx2_r[ch]),
      .mean_o (mid_nxt[CH_W*ch +: CH_W])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      mid3_r <= mid_nxt;
    end
  end

  assign s3_mid = mid3_r;

endmodule

### rtl/sbf_hpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbf_hpass
// Horizontal pass: tap line of intermediates, running row sum and the
// horizontal rounded mean.
// ----------------------------------------------------------------------------
module sbf_hpass #(
  parameter int RADIUS = 10,
  localparam int TAPS = 2 * RADIUS + 1,
  localparam int SW   = sbf_pkg::sum_w(RADIUS)
) (
  input  logic                      clk,
  input  sbf_pkg::pipe_ctl_t        ctl,
  input  logic [sbf_pkg::PIX_W-1:0] s3_mid,
  input  sbf_pkg::side_t            s3_side,
  output logic [sbf_pkg::PIX_W-1:0] s4_avg
);

  localparam int CH_W = sbf_pkg::CH_W;

  // previous intermediates, entry TAPS-1 is the oldest
  logic [sbf_pkg::PIX_W-1:0]          tap_r [TAPS];
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] hsum_r;
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] hx4_r;

  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] hsum_nxt;
  logic [sbf_pkg::NUM_CH-1:0][SW-1:0] hx_nxt;

  // running window sum per channel
  for (genvar ch = 0; ch < sbf_pkg::NUM_CH; ch++) begin : g_hsum
    logic [SW-1:0] base;
    logic [SW-1:0] old;

    assign base = s3_side.first_col ? '0 : hsum_r[ch];
    assign old  = s3_side.drop_old ? SW'(tap_r[TAPS-1][CH_W*ch +: CH_W]) : '0;
    assign hsum_nxt[ch] = (base - old) + SW'(s3_mid[CH_W*ch +: CH_W]);
    assign hx_nxt[ch]   = hsum_nxt[ch] + SW'(RADIUS);
  end

  // window state only moves on rows that carry intermediates
  always_ff @(posedge clk) begin
    if (ctl.adv3 && s3_side.live) begin
      hsum_r   <= hsum_nxt;
      tap_r[0] <= s3_mid;
      for (int k = 1; k < TAPS; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      hx4_r <= hx_nxt;
    end
  end

  // stage 4: horizontal rounded mean
  for (genvar ch = 0; ch < sbf_pkg::NUM_CH; ch++) begin : g_hmean
    sbf_rmean #(
      .RADIUS (RADIUS)
    ) u_rmean (
      .sum_i  (hx4_r[ch]),
      .mean_o (s4_avg[CH_W*ch +: CH_W])
    );
  end

endmodule

### rtl/separable_box_filter_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_box_filter_rgb
// Separable (2*RADIUS+1) square box mean filter on an RGB raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one pixel per transaction in
//   raster order. Output channel (out_valid / out_stall) returns one result
//   per interior pixel, with its row, column and a last-of-frame mark;
//   pixels closer than RADIUS to any border give no result.
//   Throughput is one pixel per cycle while the output does not stall. The
//   vertical window comes from a line store plus a per-column running sum,
//   the horizontal one from a tap line plus a running row sum, so each pixel
//   costs one read and one write per store. Stage 4 feeds the output register.
//   A stalled output holds its result; the four inner stages keep filling,
//   and in_stall rises only once they are all occupied.
//   Reset (synchronous, rst_n low) empties the pipeline, sets the frame to
//   640 x 480 and starts at row 0, column 0. Stores need no clearing pass.
//   A width or height write restarts the frame at row 0, column 0; write
//   only while no transaction is in flight.
// ----------------------------------------------------------------------------
module separable_box_filter_rgb #(
  parameter int RADIUS    = 10,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sbf_pkg::CH_W-1:0]      in_chan_zero,
  input  logic [sbf_pkg::CH_W-1:0]      in_chan_one,
  input  logic [sbf_pkg::CH_W-1:0]      in_chan_two,
  // filtered output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbf_pkg::CH_W-1:0]      out_avg_zero,
  output logic [sbf_pkg::CH_W-1:0]      out_avg_one,
  output logic [sbf_pkg::CH_W-1:0]      out_avg_two,
  output logic [sbf_pkg::ROW_W-1:0]     out_row,
  output logic [sbf_pkg::OUT_COL_W-1:0] out_col,
  output logic                          out_frame_last
);

  localparam int TAPS  = 2 * RADIUS + 1;
  localparam int LINES = 2 * RADIUS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int AW    = $clog2(LINES * MAX_WIDTH);
  localparam int IW    = $clog2(LINES);
  localparam int ROW_W = sbf_pkg::ROW_W;
  localparam int CH_W  = sbf_pkg::CH_W;

  // configuration registers
  logic [sbf_pkg::WID_CFG_W-1:0] cfg_width_r;
  logic [sbf_pkg::HGT_CFG_W-1:0] cfg_height_r;
  logic                          cfg_hit;

  // position counters
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [IW-1:0]    line_idx_r;
  logic [AW-1:0]    line_base_r;
  logic [CW-1:0]    last_col;
  logic [ROW_W-1:0] last_row;

  // pipeline control
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic                 out_valid_r;
  sbf_pkg::side_t       side_nxt;
  sbf_pkg::side_t       side1_r, side2_r, side3_r, side4_r;
  logic [CW-1:0]        col1_r;
  sbf_pkg::pipe_ctl_t   ctl;
  logic                 out_free, adv4;
  logic                 free1, free2, free3, free4;

  // datapath
  logic [sbf_pkg::PIX_W-1:0] in_pix;
  logic [AW-1:0]             line_addr;
  logic [sbf_pkg::PIX_W-1:0] s3_mid;
  logic [sbf_pkg::PIX_W-1:0] s4_avg;

  // output registers
  logic [sbf_pkg::PIX_W-1:0]     avg_r;
  logic [ROW_W-1:0]              orow_r;
  logic [sbf_pkg::OUT_COL_W-1:0] ocol_r;
  logic                          olast_r;

  // configuration writes
  assign cfg_hit = cfg_wr_en &&
                   (cfg_idx == sbf_pkg::REG_IMAGE_WIDTH ||
                    cfg_idx == sbf_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= sbf_pkg::WID_CFG_W'(sbf_pkg::RESET_WIDTH);
      cfg_height_r <= sbf_pkg::HGT_CFG_W'(sbf_pkg::RESET_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        sbf_pkg::REG_IMAGE_WIDTH: begin
          cfg_width_r <= cfg_data[sbf_pkg::WID_CFG_W-1:0];
        end
        sbf_pkg::REG_IMAGE_HEIGHT: begin
          cfg_height_r <= cfg_data[sbf_pkg::HGT_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective last column and row, zero means one and large values clamp
  always_comb begin
    logic [31:0] wid_ext;
    logic [31:0] hgt_ext;
    wid_ext = 32'(cfg_width_r);
    hgt_ext = 32'(cfg_height_r);
    if (cfg_width_r == '0) begin
      last_col = '0;
    end else if (wid_ext > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(wid_ext - 32'd1);
    end
    if (cfg_height_r == '0) begin
      last_row = '0;
    end else if (hgt_ext > 32'(sbf_pkg::MAX_HEIGHT)) begin
      last_row = ROW_W'(sbf_pkg::MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(hgt_ext - 32'd1);
    end
  end

  // handshake and stage advance, back to front
  assign out_free = !out_valid_r || !out_stall;
  assign adv4     = v4_r && (out_free || !side4_r.emit);
  assign free4    = !v4_r || adv4;
  assign ctl.adv3 = v3_r && free4;
  assign free3    = !v3_r || ctl.adv3;
  assign ctl.adv2 = v2_r && free3;
  assign free2    = !v2_r || ctl.adv2;
  assign ctl.adv1 = v1_r && free2;
  assign free1    = !v1_r || ctl.adv1;
  assign ctl.acc  = in_valid && free1;
  assign in_stall = !free1;

  // position counters, line store row base follows the row modulo LINES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      line_idx_r  <= '0;
      line_base_r <= '0;
    end else if (cfg_hit) begin
      col_r       <= '0;
      row_r       <= '0;
      line_idx_r  <= '0;
      line_base_r <= '0;
    end else if (ctl.acc) begin
      if (col_r == last_col) begin
        col_r <= '0;
        if (row_r == last_row) begin
          row_r       <= '0;
          line_idx_r  <= '0;
          line_base_r <= '0;
        end else begin
          row_r <= row_r + 1'b1;
          if (line_idx_r == IW'(LINES - 1)) begin
            line_idx_r  <= '0;
            line_base_r <= '0;
          end else begin
            line_idx_r  <= line_idx_r + 1'b1;
            line_base_r <= line_base_r + AW'(MAX_WIDTH);
          end
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  assign line_addr = line_base_r + AW'(col_r);
  assign in_pix    = {in_chan_two, in_chan_one, in_chan_zero};

  // position flags of the pixel being accepted
  always_comb begin
    logic [31:0] col_ext;
    logic [31:0] row_ext;
    logic [31:0] ocol_ext;
    col_ext  = 32'(col_r);
    row_ext  = 32'(row_r);
    ocol_ext = col_ext - 32'(RADIUS);
    side_nxt.live      = row_ext >= 32'(LINES);
    side_nxt.first_row = row_r == '0;
    side_nxt.first_col = col_r == '0;
    side_nxt.drop_old  = col_ext >= 32'(TAPS);
    side_nxt.emit      = (row_ext >= 32'(LINES)) && (col_ext >= 32'(LINES));
    side_nxt.last      = (row_r == last_row) && (col_r == last_col);
    side_nxt.row       = row_r - ROW_W'(RADIUS);
    side_nxt.col       = ocol_ext[sbf_pkg::OUT_COL_W-1:0];
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.acc) begin
        v1_r <= 1'b1;
      end else if (ctl.adv1) begin
        v1_r <= 1'b0;
      end
      if (ctl.adv1) begin
        v2_r <= 1'b1;
      end else if (ctl.adv2) begin
        v2_r <= 1'b0;
      end
      if (ctl.adv2) begin
        v3_r <= 1'b1;
      end else if (ctl.adv3) begin
        v3_r <= 1'b0;
      end
      if (ctl.adv3) begin
        v4_r <= 1'b1;
      end else if (adv4) begin
        v4_r <= 1'b0;
      end
      if (adv4 && side4_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // position info riding along the stages
  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      side1_r <= side_nxt;
      col1_r  <= col_r;
    end
    if (ctl.adv1) begin
      side2_r <= side1_r;
    end
    if (ctl.adv2) begin
      side3_r <= side2_r;
    end
    if (ctl.adv3) begin
      side4_r <= side3_r;
    end
  end

  // vertical pass
  sbf_vpass #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_vpass (
    .clk       (clk),
    .ctl       (ctl),
    .in_pix    (in_pix),
    .line_addr (line_addr),
    .in_col    (col_r),
    .s1_side   (side1_r),
    .s1_col    (col1_r),
    .s3_mid    (s3_mid)
  );

  // horizontal pass
  sbf_hpass #(
    .RADIUS (RADIUS)
  ) u_hpass (
    .clk     (clk),
    .ctl     (ctl),
    .s3_mid  (s3_mid),
    .s3_side (side3_r),
    .s4_avg  (s4_avg)
  );

  // output register
  always_ff @(posedge clk) begin
    if (adv4 && side4_r.emit) begin
      avg_r   <= s4_avg;
      orow_r  <= side4_r.row;
      ocol_r  <= side4_r.col;
      olast_r <= side4_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_avg_zero   = avg_r[0 +: CH_W];
  assign out_avg_one    = avg_r[CH_W +: CH_W];
  assign out_avg_two    = avg_r[2*CH_W +: CH_W];
  assign out_row        = orow_r;
  assign out_col        = ocol_r;
  assign out_frame_last = olast_r;

endmodule
